[design/aors_pkg.sv]
// ----------------------------------------------------------------------------
// aors_pkg: analog output ramp scaler shared definitions
// Widths, opcodes, register indexes, microcode format and the control store.
// ----------------------------------------------------------------------------
package aors_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int RAW_WIDTH     = 16;

   localparam int DATA_W  = 32;               // engineering value width
   localparam int WIDE_W  = DATA_W + 1;       // differences of two values
   localparam int CODE_W  = 16;               // raw code register width
   localparam int SPAN_W  = CODE_W + 1;       // raw_high - raw_low
   localparam int SECS_W  = 24;
   localparam int PROD_W  = SPAN_W + WIDE_W;  // shared multiplier product
   localparam int DIV_W   = PROD_W;           // dividend magnitude bits
   localparam int DVS_W   = WIDE_W;           // divisor magnitude bits
   localparam int REM_W   = DVS_W + 1;
   localparam int QS_W    = DIV_W + 1;        // signed quotient
   localparam int SUM_W   = DIV_W + 2;        // quotient plus raw_low
   localparam int CNT_W   = $clog2(DIV_W + 1);
   localparam int INCS_LO = 8;                // ramp_seconds fraction bits
   localparam int CSR_IDX_W = 3;

   localparam logic [RAW_WIDTH-1:0] RAW_MAX = '1;

   localparam logic signed [DATA_W-1:0] EU_LOW_RST     = '0;
   localparam logic signed [DATA_W-1:0] EU_HIGH_RST    = DATA_W'(100 * (2 ** FRACTION_BITS));
   localparam logic [CODE_W-1:0]        RAW_LOW_RST    = '0;
   localparam logic [CODE_W-1:0]        RAW_HIGH_RST   = CODE_W'(4095);
   localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = '0;
   localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = DATA_W'(100 * (2 ** FRACTION_BITS));
   localparam logic [CODE_W-1:0]        TICK_RATE_RST  = CODE_W'(10);

   typedef enum logic [1:0] {
      OP_SEND   = 2'd0,
      OP_RAMP   = 2'd1,
      OP_TICK   = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EU_LOW     = 3'd0,
      CSR_EU_HIGH    = 3'd1,
      CSR_RAW_LOW    = 3'd2,
      CSR_RAW_HIGH   = 3'd3,
      CSR_LIMIT_LOW  = 3'd4,
      CSR_LIMIT_HIGH = 3'd5,
      CSR_TICK_RATE  = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_LOAD,
      UOP_SEND_SET,
      UOP_TICK_ADD,
      UOP_CLAMP_HI,
      UOP_CLAMP_LO,
      UOP_SCALE_PREP,
      UOP_MUL,
      UOP_SCALE_DIV_INIT,
      UOP_DIV_STEP,
      UOP_SCALE_FIN,
      UOP_SCALE_FLAT,
      UOP_EMIT,
      UOP_RAMP_PREP,
      UOP_RAMP_DIV_INIT,
      UOP_RAMP_FIN_Q,
      UOP_RAMP_FIN_D
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,      // fall through
      COND_ALWAYS,     // jump
      COND_DISPATCH,   // wait for a transaction, then branch on its opcode
      COND_RAMP_IDLE,  // jump when no ramp is running
      COND_DEN_ZERO,   // jump when the EU span is zero
      COND_INCS_ZERO,  // jump when the ramp has no increments
      COND_DIV_MORE,   // loop while divider bits remain
      COND_OUT_BUSY    // hold while the result register is full and not taken, else jump
   } cond_type;

   typedef logic [4:0] pc_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   localparam pc_type PC_FETCH      = 5'd0;
   localparam pc_type PC_SEND       = 5'd1;
   localparam pc_type PC_TICK       = 5'd2;
   localparam pc_type PC_TICK_ADD   = 5'd3;
   localparam pc_type PC_CLAMP_HI   = 5'd4;
   localparam pc_type PC_CLAMP_LO   = 5'd5;
   localparam pc_type PC_SCALE_PREP = 5'd6;
   localparam pc_type PC_SCALE_MUL  = 5'd7;
   localparam pc_type PC_SCALE_DIV0 = 5'd8;
   localparam pc_type PC_SCALE_DIV  = 5'd9;
   localparam pc_type PC_SCALE_FIN  = 5'd10;
   localparam pc_type PC_SCALE_FLAT = 5'd11;
   localparam pc_type PC_EMIT       = 5'd12;
   localparam pc_type PC_RAMP       = 5'd13;
   localparam pc_type PC_RAMP_MUL   = 5'd14;
   localparam pc_type PC_RAMP_DIV0  = 5'd15;
   localparam pc_type PC_RAMP_DIV   = 5'd16;
   localparam pc_type PC_RAMP_FIN   = 5'd17;
   localparam pc_type PC_RAMP_ZERO  = 5'd18;

   // Control store
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_FETCH:      w = '{UOP_LOAD,           COND_DISPATCH,  PC_FETCH};
         PC_SEND:       w = '{UOP_SEND_SET,       COND_ALWAYS,    PC_CLAMP_HI};
         PC_TICK:       w = '{UOP_NOP,            COND_RAMP_IDLE, PC_FETCH};
         PC_TICK_ADD:   w = '{UOP_TICK_ADD,       COND_NEVER,     PC_FETCH};
         PC_CLAMP_HI:   w = '{UOP_CLAMP_HI,       COND_NEVER,     PC_FETCH};
         PC_CLAMP_LO:   w = '{UOP_CLAMP_LO,       COND_NEVER,     PC_FETCH};
         PC_SCALE_PREP: w = '{UOP_SCALE_PREP,     COND_NEVER,     PC_FETCH};
         PC_SCALE_MUL:  w = '{UOP_MUL,            COND_DEN_ZERO,  PC_SCALE_FLAT};
         PC_SCALE_DIV0: w = '{UOP_SCALE_DIV_INIT, COND_NEVER,     PC_FETCH};
         PC_SCALE_DIV:  w = '{UOP_DIV_STEP,       COND_DIV_MORE,  PC_SCALE_DIV};
         PC_SCALE_FIN:  w = '{UOP_SCALE_FIN,      COND_ALWAYS,    PC_EMIT};
         PC_SCALE_FLAT: w = '{UOP_SCALE_FLAT,     COND_NEVER,     PC_FETCH};
         PC_EMIT:       w = '{UOP_EMIT,           COND_OUT_BUSY,  PC_FETCH};
         PC_RAMP:       w = '{UOP_RAMP_PREP,      COND_NEVER,     PC_FETCH};
         PC_RAMP_MUL:   w = '{UOP_MUL,            COND_NEVER,     PC_FETCH};
         PC_RAMP_DIV0:  w = '{UOP_RAMP_DIV_INIT,  COND_INCS_ZERO, PC_RAMP_ZERO};
         PC_RAMP_DIV:   w = '{UOP_DIV_STEP,       COND_DIV_MORE,  PC_RAMP_DIV};
         PC_RAMP_FIN:   w = '{UOP_RAMP_FIN_Q,     COND_ALWAYS,    PC_FETCH};
         PC_RAMP_ZERO:  w = '{UOP_RAMP_FIN_D,     COND_ALWAYS,    PC_FETCH};
         default:       w = '{UOP_NOP,            COND_ALWAYS,    PC_FETCH};
      endcase
      return w;
   endfunction

   function automatic pc_type dispatch_pc(input opcode_type op);
      pc_type p;
      case (op)
         OP_SEND: p = PC_SEND;
         OP_RAMP: p = PC_RAMP;
         OP_TICK: p = PC_TICK;
         default: p = PC_FETCH;
      endcase
      return p;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [QS_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if ((&v[QS_W-1:DATA_W-1]) || !(|v[QS_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[QS_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [RAW_WIDTH-1:0] sat_raw(input logic signed [SUM_W-1:0] v);
      logic [RAW_WIDTH-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (|v[SUM_W-2:RAW_WIDTH]) begin
         r = RAW_MAX;
      end else begin
         r = v[RAW_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

[design/analog_output_ramp_scaler.sv]
// ----------------------------------------------------------------------------
// analog_output_ramp_scaler
// Setpoint ramp generator with clamping and linear scaling to a converter code.
// ----------------------------------------------------------------------------
// One transaction is worked at a time by a small microcoded sequencer. The
// shared restoring divider produces one quotient bit per cycle over a 50-bit
// dividend and serves both the scaling of sends and active ticks and the step
// of a ramp start. With equal EU bounds the divider is skipped for a send or an
// active tick; a ramp start with no increments, an idle tick and the unused
// opcode do not use it.
// The next transaction is accepted while a result still waits in the output
// register; it stalls only when it reaches its own emit step.
// Configuration writes take effect on the next clock.
module analog_output_ramp_scaler
   import aors_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic signed [DATA_W-1:0]   req_target,
   input  logic [SECS_W-1:0]          req_ramp_seconds,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [RAW_WIDTH-1:0]       rsp_raw_code,
   output logic signed [DATA_W-1:0]   rsp_present_eu,
   output logic                       rsp_ramping,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [DATA_W-1:0]          csr_wdata
);

   // sequencer
   pc_type pc_ff, pc_in;
   ucode_type uw;

   // configuration
   logic signed [DATA_W-1:0] eu_low_ff, eu_low_in, eu_high_ff, eu_high_in;
   logic signed [DATA_W-1:0] limit_low_ff, limit_low_in, limit_high_ff, limit_high_in;
   logic [CODE_W-1:0] raw_low_ff, raw_low_in, raw_high_ff, raw_high_in;
   logic [CODE_W-1:0] tick_rate_ff, tick_rate_in;

   // channel state
   logic signed [DATA_W-1:0] present_ff, present_in, goal_ff, goal_in, step_ff, step_in;
   logic ramp_active_ff, ramp_active_in;

   // datapath
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic [SECS_W-1:0]        secs_ff, secs_in;
   logic signed [WIDE_W-1:0] val_ff, val_in, db_ff, db_in, den_ff, den_in;
   logic signed [SPAN_W-1:0] da_ff, da_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]         num_ff, num_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DVS_W-1:0]         dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [RAW_WIDTH-1:0]     raw_ff, raw_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic [RAW_WIDTH-1:0]       out_raw_ff, out_raw_in;
   logic signed [DATA_W-1:0]   out_eu_ff, out_eu_in;
   logic                       out_ramp_ff, out_ramp_in;

   // combinational helpers
   logic                     accept, out_busy;
   logic signed [WIDE_W-1:0] sum, present_x, goal_x, lim_hi_x, lim_lo_x, eu_low_x;
   logic [REM_W-1:0]         rem_shift;
   logic [REM_W:0]           trial;
   logic signed [QS_W-1:0]   qs, step_src, step_fix;
   logic signed [SUM_W-1:0]  raw_sum;
   logic [DATA_W-1:0]        incs;

   assign uw        = ucode_rom(pc_ff);
   assign req_ready = (pc_ff == PC_FETCH);
   assign accept    = req_valid && req_ready;
   assign out_busy  = out_valid_ff && !rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_raw_code   = out_raw_ff;
   assign rsp_present_eu = out_eu_ff;
   assign rsp_ramping    = out_ramp_ff;

   assign present_x = {present_ff[DATA_W-1], present_ff};
   assign goal_x    = {goal_ff[DATA_W-1], goal_ff};
   assign lim_hi_x  = {limit_high_ff[DATA_W-1], limit_high_ff};
   assign lim_lo_x  = {limit_low_ff[DATA_W-1], limit_low_ff};
   assign eu_low_x  = {eu_low_ff[DATA_W-1], eu_low_ff};
   assign sum       = present_x + {step_ff[DATA_W-1], step_ff};
   assign incs      = prod_ff[INCS_LO+DATA_W-1:INCS_LO];

   assign rem_shift = {rem_ff[REM_W-2:0], num_ff[DIV_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign qs        = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
   assign raw_sum   = {qs[QS_W-1], qs} + $signed({{(SUM_W-CODE_W){1'b0}}, raw_low_ff});

   // ramp step: quotient, or the whole difference when there are no increments;
   // a nonzero difference always moves at least one LSB
   always_comb begin
      step_src = (uw.uop == UOP_RAMP_FIN_D) ? QS_W'(val_ff) : qs;
      step_fix = step_src;
      if (step_src == '0 && val_ff != '0) begin
         step_fix = val_ff[WIDE_W-1] ? -QS_W'(1) : QS_W'(1);
      end
   end

   // sequencer
   always_comb begin
      pc_in = pc_ff + 5'd1;
      case (uw.cond)
         COND_NEVER:     pc_in = pc_ff + 5'd1;
         COND_ALWAYS:    pc_in = uw.target;
         COND_DISPATCH:  pc_in = req_valid ? dispatch_pc(opcode_type'(req_opcode)) : pc_ff;
         COND_RAMP_IDLE: pc_in = ramp_active_ff ? pc_ff + 5'd1 : uw.target;
         COND_DEN_ZERO:  pc_in = (den_ff == '0) ? uw.target : pc_ff + 5'd1;
         COND_INCS_ZERO: pc_in = (incs == '0) ? uw.target : pc_ff + 5'd1;
         COND_DIV_MORE:  pc_in = (cnt_ff != CNT_W'(1)) ? uw.target : pc_ff + 5'd1;
         COND_OUT_BUSY:  pc_in = out_busy ? pc_ff : uw.target;
         default:        pc_in = PC_FETCH;
      endcase
   end

   // configuration writes
   always_comb begin
      eu_low_in     = eu_low_ff;
      eu_high_in    = eu_high_ff;
      raw_low_in    = raw_low_ff;
      raw_high_in   = raw_high_ff;
      limit_low_in  = limit_low_ff;
      limit_high_in = limit_high_ff;
      tick_rate_in  = tick_rate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EU_LOW:     eu_low_in     = csr_wdata;
            CSR_EU_HIGH:    eu_high_in    = csr_wdata;
            CSR_RAW_LOW:    raw_low_in    = csr_wdata[CODE_W-1:0];
            CSR_RAW_HIGH:   raw_high_in   = csr_wdata[CODE_W-1:0];
            CSR_LIMIT_LOW:  limit_low_in  = csr_wdata;
            CSR_LIMIT_HIGH: limit_high_in = csr_wdata;
            CSR_TICK_RATE:  tick_rate_in  = csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath, one micro-operation per cycle
   always_comb begin
      present_in     = present_ff;
      goal_in        = goal_ff;
      step_in        = step_ff;
      ramp_active_in = ramp_active_ff;
      target_in      = target_ff;
      secs_in        = secs_ff;
      val_in         = val_ff;
      da_in          = da_ff;
      db_in          = db_ff;
      den_in         = den_ff;
      prod_in        = prod_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      raw_in         = raw_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_raw_in     = out_raw_ff;
      out_eu_in      = out_eu_ff;
      out_ramp_in    = out_ramp_ff;

      case (uw.uop)
         UOP_NOP: ;
         UOP_LOAD: begin
            if (accept) begin
               target_in = req_target;
               secs_in   = req_ramp_seconds;
            end
         end
         UOP_SEND_SET: begin
            ramp_active_in = 1'b0;
            val_in         = {target_ff[DATA_W-1], target_ff};
         end
         UOP_TICK_ADD: begin
            val_in = sum;
            if (step_ff > 0) begin
               if (sum >= goal_x) begin
                  val_in         = goal_x;
                  ramp_active_in = 1'b0;
               end
            end else if (step_ff < 0) begin
               if (sum <= goal_x) begin
                  val_in         = goal_x;
                  ramp_active_in = 1'b0;
               end
            end else begin
               val_in         = goal_x;
               ramp_active_in = 1'b0;
            end
         end
         UOP_CLAMP_HI: begin
            if (val_ff > lim_hi_x) begin
               val_in = lim_hi_x;
            end
         end
         UOP_CLAMP_LO: begin
            if (val_ff < lim_lo_x) begin
               val_in = lim_lo_x;
            end
         end
         UOP_SCALE_PREP: begin
            present_in = val_ff[DATA_W-1:0];
            da_in      = $signed({1'b0, raw_high_ff}) - $signed({1'b0, raw_low_ff});
            db_in      = {val_ff[DATA_W-1], val_ff[DATA_W-1:0]} - eu_low_x;
            den_in     = {eu_high_ff[DATA_W-1], eu_high_ff} - eu_low_x;
         end
         UOP_MUL: begin
            prod_in = da_ff * db_ff;
         end
         UOP_SCALE_DIV_INIT: begin
            num_in = prod_ff[PROD_W-1] ? DIV_W'(-prod_ff) : DIV_W'(prod_ff);
            dvs_in = den_ff[WIDE_W-1] ? DVS_W'(-den_ff) : DVS_W'(den_ff);
            neg_in = prod_ff[PROD_W-1] ^ den_ff[WIDE_W-1];
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W);
         end
         UOP_RAMP_PREP: begin
            val_in = {target_ff[DATA_W-1], target_ff} - present_x;
            da_in  = $signed({1'b0, tick_rate_ff});
            db_in  = $signed({{(WIDE_W-SECS_W){1'b0}}, secs_ff});
         end
         UOP_RAMP_DIV_INIT: begin
            num_in = DIV_W'(val_ff[WIDE_W-1] ? DVS_W'(-val_ff) : DVS_W'(val_ff));
            dvs_in = {1'b0, incs};
            neg_in = val_ff[WIDE_W-1];
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W);
         end
         UOP_DIV_STEP: begin
            // restoring step: keep the trial remainder when it does not borrow
            if (!trial[REM_W]) begin
               rem_in = trial[REM_W-1:0];
            end else begin
               rem_in = rem_shift;
            end
            num_in = {num_ff[DIV_W-2:0], !trial[REM_W]};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         UOP_SCALE_FIN: begin
            raw_in = sat_raw(raw_sum);
         end
         UOP_SCALE_FLAT: begin
            raw_in = sat_raw($signed({{(SUM_W-CODE_W){1'b0}}, raw_low_ff}));
         end
         UOP_EMIT: begin
            if (!out_busy) begin
               out_valid_in = 1'b1;
               out_raw_in   = raw_ff;
               out_eu_in    = present_ff;
               out_ramp_in  = ramp_active_ff;
            end
         end
         UOP_RAMP_FIN_Q, UOP_RAMP_FIN_D: begin
            step_in        = sat32(step_fix);
            goal_in        = target_ff;
            ramp_active_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= PC_FETCH;
         eu_low_ff      <= EU_LOW_RST;
         eu_high_ff     <= EU_HIGH_RST;
         raw_low_ff     <= RAW_LOW_RST;
         raw_high_ff    <= RAW_HIGH_RST;
         limit_low_ff   <= LIMIT_LOW_RST;
         limit_high_ff  <= LIMIT_HIGH_RST;
         tick_rate_ff   <= TICK_RATE_RST;
         present_ff     <= '0;
         goal_ff        <= '0;
         step_ff        <= '0;
         ramp_active_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         pc_ff          <= pc_in;
         eu_low_ff      <= eu_low_in;
         eu_high_ff     <= eu_high_in;
         raw_low_ff     <= raw_low_in;
         raw_high_ff    <= raw_high_in;
         limit_low_ff   <= limit_low_in;
         limit_high_ff  <= limit_high_in;
         tick_rate_ff   <= tick_rate_in;
         present_ff     <= present_in;
         goal_ff        <= goal_in;
         step_ff        <= step_in;
         ramp_active_ff <= ramp_active_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      secs_ff     <= secs_in;
      val_ff      <= val_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      raw_ff      <= raw_in;
      out_raw_ff  <= out_raw_in;
      out_eu_ff   <= out_eu_in;
      out_ramp_ff <= out_ramp_in;
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: analog output ramp scaler
// Sends, ramp starts and update ticks go through the request channel under
// several register settings. An in-bench model of the clamp, scale and ramp
// arithmetic predicts each output code, and the monitor checks every result
// field by field.
// ----------------------------------------------------------------------------
module testbench;
   import aors_pkg::*;

   localparam longint ONE_EU          = 65536;
   localparam int     NUM_PHASES      = 10;
   localparam int     ITEMS_PER_PHASE = 170;
   localparam int     SETTLE_CYCLES   = 100;
   localparam int     STALL_LIMIT     = 4000;

   localparam logic signed [DATA_W-1:0] EU_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] EU_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      opcode_type            opcode;
      logic [DATA_W-1:0]     target;
      logic [SECS_W-1:0]     seconds;
   } command_type;

   typedef struct packed {
      logic [RAW_WIDTH-1:0]  raw_code;
      logic [DATA_W-1:0]     present_eu;
      logic                  ramping;
   } output_code_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_opcode       = '0;
   logic signed [DATA_W-1:0] req_target       = '0;
   logic [SECS_W-1:0]        req_ramp_seconds = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [RAW_WIDTH-1:0]     rsp_raw_code;
   logic signed [DATA_W-1:0] rsp_present_eu;
   logic                     rsp_ramping;
   logic                     csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index        = '0;
   logic [DATA_W-1:0]        csr_wdata        = '0;

   // register copies used for prediction and for shaping the stimulus
   longint cfg_eu_low     = EU_LOW_RST;
   longint cfg_eu_high    = EU_HIGH_RST;
   longint cfg_raw_low    = RAW_LOW_RST;
   longint cfg_raw_high   = RAW_HIGH_RST;
   longint cfg_limit_low  = LIMIT_LOW_RST;
   longint cfg_limit_high = LIMIT_HIGH_RST;
   longint cfg_tick_rate  = TICK_RATE_RST;

   // output channel state
   logic signed [DATA_W-1:0] present_q   = '0;
   logic                     ramp_on     = 1'b0;
   logic signed [DATA_W-1:0] ramp_goal_q = '0;
   logic signed [DATA_W-1:0] ramp_step_q = '0;

   command_type     cmd_queue[$];
   output_code_type code_queue[$];

   int pushed_count   = 0;
   int accepted_count = 0;
   int phase_items    = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   analog_output_ramp_scaler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_target       (req_target),
      .req_ramp_seconds (req_ramp_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_code     (rsp_raw_code),
      .rsp_present_eu   (rsp_present_eu),
      .rsp_ramping      (rsp_ramping),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   // clamp to the output limits, record the value and map it to a code
   function automatic output_code_type clamp_and_scale(input longint level);
      output_code_type r;
      longint       v;
      longint       span;
      longint       raw;
      longint       raw_top;
      v       = level;
      span    = cfg_eu_high - cfg_eu_low;
      raw_top = (longint'(1) << RAW_WIDTH) - 1;
      if (v > cfg_limit_high) v = cfg_limit_high;
      if (v < cfg_limit_low) v = cfg_limit_low;
      present_q = 32'(v);
      if (span == 0) raw = cfg_raw_low;
      else raw = (cfg_raw_high - cfg_raw_low) * (v - cfg_eu_low) / span + cfg_raw_low;
      if (raw < 0) raw = 0;
      if (raw > raw_top) raw = raw_top;
      r.raw_code   = RAW_WIDTH'(raw);
      r.present_eu = present_q;
      r.ramping    = ramp_on;
      return r;
   endfunction

   task automatic apply_command(input opcode_type op, input logic signed [DATA_W-1:0] goal,
                                input logic [SECS_W-1:0] secs);
      longint diff;
      longint incs;
      longint step;
      longint sum;
      case (op)
         OP_SEND: begin
            ramp_on = 1'b0;
            code_queue.push_back(clamp_and_scale(goal));
         end
         OP_RAMP: begin
            diff = longint'(goal) - longint'(present_q);
            incs = (longint'(secs) * cfg_tick_rate) >>> INCS_LO;
            step = (incs != 0) ? diff / incs : diff;
            // a difference smaller than the tick count still moves one LSB
            if (step == 0 && diff != 0) step = (diff > 0) ? 1 : -1;
            ramp_on     = 1'b1;
            ramp_goal_q = goal;
            if (step > EU_MAX) ramp_step_q = EU_MAX;
            else if (step < EU_MIN) ramp_step_q = EU_MIN;
            else ramp_step_q = 32'(step);
         end
         OP_TICK: begin
            if (ramp_on) begin
               sum = longint'(present_q) + longint'(ramp_step_q);
               if (ramp_step_q == 0 ||
                   (ramp_step_q > 0 && sum >= longint'(ramp_goal_q)) ||
                   (ramp_step_q < 0 && sum <= longint'(ramp_goal_q))) begin
                  sum     = ramp_goal_q;
                  ramp_on = 1'b0;
               end
               code_queue.push_back(clamp_and_scale(sum));
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      command_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = cmd_queue.pop_front();
            req_valid        <= 1'b1;
            req_opcode       <= next_cmd.opcode;
            req_target       <= next_cmd.target;
            req_ramp_seconds <= next_cmd.seconds;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      output_code_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (code_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected: raw_code %0d present_eu %0d ramping %0d",
                        $time, rsp_raw_code, rsp_present_eu, rsp_ramping);
            end else begin
               want = code_queue.pop_front();
               if (rsp_raw_code !== want.raw_code) begin
                  mismatch_count++;
                  $display("%0t: raw_code expected %0d actual %0d",
                           $time, want.raw_code, rsp_raw_code);
               end
               if (rsp_present_eu !== want.present_eu) begin
                  mismatch_count++;
                  $display("%0t: present_eu expected %0d actual %0d",
                           $time, $signed(want.present_eu), rsp_present_eu);
               end
               if (rsp_ramping !== want.ramping) begin
                  mismatch_count++;
                  $display("%0t: ramping expected %0d actual %0d",
                           $time, want.ramping, rsp_ramping);
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_command(opcode_type'(req_opcode), req_target, req_ramp_seconds);
            accepted_count++;
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_cmd(input opcode_type op, input logic [DATA_W-1:0] goal,
                           input logic [SECS_W-1:0] secs);
      command_type c;
      c.opcode  = op;
      c.target  = goal;
      c.seconds = secs;
      cmd_queue.push_back(c);
      pushed_count++;
      if (op != OP_UNUSED) phase_items++;
   endtask

   // ramp start followed by a tick per increment, capped for long ramps, plus extra ticks
   task automatic queue_ramp(input logic [DATA_W-1:0] goal, input logic [SECS_W-1:0] secs,
                             input int extra);
      longint steps;
      steps = (longint'(secs) * cfg_tick_rate) >>> INCS_LO;
      push_cmd(OP_RAMP, goal, secs);
      repeat ((steps > 30 ? 30 : int'(steps)) + extra)
         push_cmd(OP_TICK, $urandom, SECS_W'($urandom));
   endtask

   function automatic logic [DATA_W-1:0] pick_level();
      longint lo;
      longint hi;
      lo = (cfg_limit_low < cfg_limit_high) ? cfg_limit_low : cfg_limit_high;
      hi = (cfg_limit_low < cfg_limit_high) ? cfg_limit_high : cfg_limit_low;
      case ($urandom_range(9))
         0: return EU_MIN;
         1: return EU_MAX;
         2: return 32'(cfg_limit_low);
         3: return 32'(cfg_limit_high);
         4, 5, 6: return 32'(lo + longint'($urandom) % (hi - lo + 1));
         7: return 32'(cfg_limit_high + $urandom_range(0, 200) - 100);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SECS_W-1:0] pick_duration();
      if ($urandom_range(9) == 0) return SECS_W'($urandom);
      return SECS_W'((longint'($urandom_range(0, 12)) * 256 + $urandom_range(0, 255))
                     / cfg_tick_rate);
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_EU_LOW:     cfg_eu_low     = longint'($signed(data));
         CSR_EU_HIGH:    cfg_eu_high    = longint'($signed(data));
         CSR_RAW_LOW:    cfg_raw_low    = longint'(data[CODE_W-1:0]);
         CSR_RAW_HIGH:   cfg_raw_high   = longint'(data[CODE_W-1:0]);
         CSR_LIMIT_LOW:  cfg_limit_low  = longint'($signed(data));
         CSR_LIMIT_HIGH: cfg_limit_high = longint'($signed(data));
         CSR_TICK_RATE:  cfg_tick_rate  = longint'(data[CODE_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic program_regs(input longint eu_lo, input longint eu_hi, input longint raw_lo,
                               input longint raw_hi, input longint lim_lo, input longint lim_hi,
                               input longint rate);
      write_reg(CSR_EU_LOW, 32'(eu_lo));
      write_reg(CSR_EU_HIGH, 32'(eu_hi));
      write_reg(CSR_RAW_LOW, 32'(raw_lo));
      write_reg(CSR_RAW_HIGH, 32'(raw_hi));
      write_reg(CSR_LIMIT_LOW, 32'(lim_lo));
      write_reg(CSR_LIMIT_HIGH, 32'(lim_hi));
      write_reg(CSR_TICK_RATE, 32'(rate));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until every transaction is done, then let a silent ramp start finish
   task automatic wait_idle();
      while (accepted_count != pushed_count || code_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                pick;
      longint            base;
      longint            extent;
      logic [DATA_W-1:0] last_goal;
      last_goal = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) wait_idle();
         case (phase)
            0: program_regs(-100 * ONE_EU, 100 * ONE_EU, 0, 65535, EU_MIN, EU_MAX, 1);
            1: program_regs(EU_MIN, EU_MAX, 65535, 0, -50 * ONE_EU, 50 * ONE_EU, 65535);
            // equal EU bounds, crossed limits
            2: program_regs(5 * ONE_EU, 5 * ONE_EU, 1234, 9, 10 * ONE_EU, -10 * ONE_EU, 100);
            3: program_regs(0, 10 * ONE_EU, 100, 4000, -20 * ONE_EU, 20 * ONE_EU, 7);
            4: program_regs(EU_LOW_RST, EU_HIGH_RST, RAW_LOW_RST, RAW_HIGH_RST,
                            LIMIT_LOW_RST, LIMIT_HIGH_RST, TICK_RATE_RST);
            default: begin
               base   = (longint'($urandom_range(0, 2000)) - 1000) * ONE_EU;
               extent = longint'($urandom_range(0, 400)) * ONE_EU + $urandom_range(0, 65535);
               if ($urandom_range(3) == 0) extent = -extent;
               program_regs(base, base + extent, $urandom_range(0, 65535),
                            $urandom_range(0, 65535),
                            base - longint'($urandom_range(0, 50)) * ONE_EU,
                            base + extent + longint'($urandom_range(0, 50)) * ONE_EU,
                            $urandom_range(1, 2000));
            end
         endcase

         case (phase * 3 / NUM_PHASES)
            0: begin send_idle_pct = 17; recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase

         if (phase == 0) begin
            push_cmd(OP_TICK, '0, '0);                    // idle tick
            push_cmd(OP_UNUSED, '1, '1);
            push_cmd(OP_SEND, EU_MAX, '0);                // raw saturates high
            push_cmd(OP_SEND, EU_MIN, '0);                // raw saturates low
            queue_ramp(EU_MAX, '0, 4);                    // jump, step saturated
            push_cmd(OP_SEND, '0, '0);
            queue_ramp('0, 24'd256, 1);                   // zero difference
            queue_ramp(32'd3, 24'd2560, 0);               // difference below tick count
            queue_ramp(32'(-5 * ONE_EU), 24'd512, 1);
            push_cmd(OP_SEND, 32'(50 * ONE_EU), '1);
            queue_ramp(32'h7fff_0000, '1, 1);             // longest ramp, cut short
            push_cmd(OP_SEND, 32'(-150 * ONE_EU), '0);
         end

         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               last_goal = pick_level();
               queue_ramp(last_goal, pick_duration(), $urandom_range(0, 2));
            end else if (pick < 52) begin
               // same goal again: usually a zero difference
               queue_ramp(last_goal, pick_duration(), 1);
            end else if (pick < 60) begin
               // ramp cut off by a send
               queue_ramp(pick_level(), SECS_W'($urandom), $urandom_range(1, 3));
               push_cmd(OP_SEND, pick_level(), SECS_W'($urandom));
            end else if (pick < 80) begin
               push_cmd(OP_SEND, pick_level(), SECS_W'($urandom));
            end else if (pick < 90) begin
               push_cmd(OP_TICK, $urandom, SECS_W'($urandom));
            end else if (pick < 96) begin
               queue_ramp(pick_level(), '0, $urandom_range(1, 2));
            end else begin
               push_cmd(OP_UNUSED, $urandom, SECS_W'($urandom));
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && code_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
design/aors_pkg.sv
design/analog_output_ramp_scaler.sv
sim/testbench.sv
